/* rtl/spt_pkg.sv */
package spt_pkg;

	localparam int COORD_W = 16;
	localparam int TOL_W   = 15;
	localparam int LEN_W   = 34;
	localparam int TOL2_W  = 30;
	localparam int A_W     = 37;
	localparam int B_W     = 19;
	localparam int P_W     = A_W + B_W;
	localparam int ACC_W   = 72;

	localparam logic [TOL_W-1:0] TOL_RESET = 15'd16;

	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_PICK = 2'd1;
	localparam logic [1:0] ACT_DEL  = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMATCH = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// Steps of the per-segment distance test.
	localparam logic [3:0] STP_DXDX  = 4'd0;
	localparam logic [3:0] STP_DYDY  = 4'd1;
	localparam logic [3:0] STP_DYX   = 4'd2;
	localparam logic [3:0] STP_DXY   = 4'd3;
	localparam logic [3:0] STP_X2Y1  = 4'd4;
	localparam logic [3:0] STP_Y2X1  = 4'd5;
	localparam logic [3:0] STP_TOLSQ = 4'd6;
	localparam logic [3:0] STP_NUM   = 4'd7;
	localparam logic [3:0] STP_ALO   = 4'd8;
	localparam logic [3:0] STP_AHI   = 4'd9;
	localparam logic [3:0] STP_TLO   = 4'd10;
	localparam logic [3:0] STP_THI   = 4'd11;
	localparam logic [3:0] STP_WAIT  = 4'd12;
	localparam logic [3:0] STP_LAST  = 4'd13;

	typedef enum logic [1:0] {SH_NONE, SH_15, SH_18} shift_t;

	typedef struct packed {
		logic                  vld;
		logic                  clr;
		logic                  neg;
		shift_t                sh;
		logic signed [A_W-1:0] a;
		logic signed [B_W-1:0] b;
	} mac_op_t;

	typedef enum logic [2:0] {
		S_IDLE, S_ADD, S_RD, S_CHK, S_MATH, S_SH_RD, S_SH_WR, S_DONE
	} state_t;

endpackage

/* rtl/spt_ram.sv */
module spt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/spt_mac.sv */
module spt_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  spt_pkg::mac_op_t                     op,
	output logic signed [spt_pkg::ACC_W-1:0]     acc_q
);
	import spt_pkg::*;

	logic signed [P_W-1:0]   prod_s1;
	logic                    vld_s1;
	logic                    clr_s1;
	logic                    neg_s1;
	shift_t                  sh_s1;
	logic signed [ACC_W-1:0] pext;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op.a * op.b;
		clr_s1  <= op.clr;
		neg_s1  <= op.neg;
		sh_s1   <= op.sh;
	end

	always_comb begin
		pext = ACC_W'(prod_s1);
		case (sh_s1)
			SH_15:   term = pext <<< 15;
			SH_18:   term = pext <<< 18;
			default: term = pext;
		endcase
		base = clr_s1 ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= neg_s1 ? base - term : base + term;
		end
	end
endmodule

/* rtl/segment_pick_table.sv */
// Segment pick table: an ordered table of line segments with signed Q12.4
// endpoints. Commands arrive on the s_axis channel, one transfer per command,
// with the action in tuser: add appends a segment, delete removes the first
// exact match and closes the gap, pick returns the first segment whose grown
// bounding box holds the point and whose line lies within the tolerance.
// Every command gives exactly one result transfer on m_axis: status in tuser,
// segment index in tdata. The tolerance is written on the cfg channel, which
// is always ready and should only be written while the block is idle.
// One command is handled at a time; s_axis_tready is high only while idle.
// An add writes the new entry at the end of the table. A pick reads each segment
// in turn and runs the distance test only on one whose box holds the point. A
// delete scans for the match, then moves each later entry down. The test runs on one
// shared multiply-accumulate unit, eleven multiplies per segment, and the
// table scan reads one entry at a time from a single RAM.
// A finished result sits in an output register; the block returns to idle as
// soon as the result is loaded there, so a stalled receiver holds only the
// next result back. Reset empties the table and sets the tolerance to 16;
// the RAM itself is not cleared, since only entries below the count are read.
module segment_pick_table #(
	parameter int MAX_SEGMENTS = 256,
	parameter int COORD_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [spt_pkg::TOL_W-1:0]   cfg_data,       // tolerance
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [63:0]                 s_axis_tdata,   // first_x, first_y, second_x, second_y
	input  logic [1:0]                  s_axis_tuser,   // action
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,   // entry_index
	output logic [1:0]                  m_axis_tuser    // status
);
	import spt_pkg::*;

	localparam int CW    = (COORD_BITS >= 16) ? 16 : COORD_BITS;
	localparam int AW    = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int RW    = 4 * CW;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

	state_t state_q, state_d;

	logic [TOL_W-1:0]          tol_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          idx_q;
	logic [CNT_W-1:0]          idx_inc;
	logic [CNT_W-1:0]          res_idx_q;
	logic [1:0]                res_st_q;
	logic [1:0]                act_q;
	logic [3:0]                step_q;
	logic signed [COORD_W-1:0] kx1_q, ky1_q, kx2_q, ky2_q;
	logic signed [COORD_W-1:0] sx1_q, sy1_q, sx2_q, sy2_q;
	logic signed [COORD_W-1:0] rx1, ry1, rx2, ry2;
	logic [LEN_W-1:0]          len2_q;
	logic [LEN_W-1:0]          anum_q;
	logic [TOL2_W-1:0]         tol2_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   acc_abs;
	mac_op_t                   op;

	logic                      m_valid_q;
	logic [1:0]                m_status_q;
	logic [7:0]                m_index_q;

	logic                      in_xfer;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [RW-1:0]             ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [RW-1:0]             ram_rdata;

	logic signed [16:0]        dx, dy;
	logic signed [17:0]        px_e, py_e, tol_e, minx, maxx, miny, maxy;
	logic                      box_ok, hit, key_match, out_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = m_index_q;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign idx_inc       = idx_q + 1'b1;

	// Stored entries keep CW bits per coordinate.
	assign rx1 = COORD_W'($signed(ram_rdata[0*CW +: CW]));
	assign ry1 = COORD_W'($signed(ram_rdata[1*CW +: CW]));
	assign rx2 = COORD_W'($signed(ram_rdata[2*CW +: CW]));
	assign ry2 = COORD_W'($signed(ram_rdata[3*CW +: CW]));
	assign key_match = (rx1 == kx1_q) && (ry1 == ky1_q) && (rx2 == kx2_q) && (ry2 == ky2_q);

	// Grown bounding box test on the loaded segment; the point is kx1/ky1.
	always_comb begin
		dx    = 17'(sx2_q) - 17'(sx1_q);
		dy    = 17'(sy2_q) - 17'(sy1_q);
		px_e  = 18'(kx1_q);
		py_e  = 18'(ky1_q);
		tol_e = {3'b000, tol_q};
		minx  = (sx1_q < sx2_q) ? 18'(sx1_q) : 18'(sx2_q);
		maxx  = (sx1_q < sx2_q) ? 18'(sx2_q) : 18'(sx1_q);
		miny  = (sy1_q < sy2_q) ? 18'(sy1_q) : 18'(sy2_q);
		maxy  = (sy1_q < sy2_q) ? 18'(sy2_q) : 18'(sy1_q);
		box_ok = !((px_e + tol_e < minx) || (px_e - tol_e > maxx) ||
		           (py_e + tol_e < miny) || (py_e - tol_e > maxy));
		acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
		// The accumulator ends holding tol^2*len^2 - num^2.
		hit = (len2_q == '0) || !acc_q[ACC_W-1];
	end

	// Operand schedule of the shared multiply-accumulate unit.
	always_comb begin
		op     = '0;
		op.sh  = SH_NONE;
		if (state_q == S_MATH) begin
			case (step_q)
				STP_DXDX: begin
					op.vld = 1'b1; op.clr = 1'b1; op.a = A_W'(dx); op.b = B_W'(dx);
				end
				STP_DYDY: begin
					op.vld = 1'b1; op.a = A_W'(dy); op.b = B_W'(dy);
				end
				STP_DYX: begin
					op.vld = 1'b1; op.clr = 1'b1; op.a = A_W'(dy); op.b = B_W'(kx1_q);
				end
				STP_DXY: begin
					op.vld = 1'b1; op.neg = 1'b1; op.a = A_W'(dx); op.b = B_W'(ky1_q);
				end
				STP_X2Y1: begin
					op.vld = 1'b1; op.a = A_W'(sx2_q); op.b = B_W'(sy1_q);
				end
				STP_Y2X1: begin
					op.vld = 1'b1; op.neg = 1'b1; op.a = A_W'(sy2_q); op.b = B_W'(sx1_q);
				end
				STP_TOLSQ: begin
					op.vld = 1'b1; op.clr = 1'b1;
					op.a = $signed({{(A_W-TOL_W){1'b0}}, tol_q});
					op.b = $signed({{(B_W-TOL_W){1'b0}}, tol_q});
				end
				STP_ALO: begin
					op.vld = 1'b1; op.clr = 1'b1; op.neg = 1'b1;
					op.a = $signed({{(A_W-LEN_W){1'b0}}, anum_q});
					op.b = $signed({1'b0, anum_q[17:0]});
				end
				STP_AHI: begin
					op.vld = 1'b1; op.neg = 1'b1; op.sh = SH_18;
					op.a = $signed({{(A_W-LEN_W){1'b0}}, anum_q});
					op.b = $signed({3'b000, anum_q[33:18]});
				end
				STP_TLO: begin
					op.vld = 1'b1;
					op.a = $signed({{(A_W-LEN_W){1'b0}}, len2_q});
					op.b = $signed({4'b0000, tol2_q[14:0]});
				end
				STP_THI: begin
					op.vld = 1'b1; op.sh = SH_15;
					op.a = $signed({{(A_W-LEN_W){1'b0}}, len2_q});
					op.b = $signed({4'b0000, tol2_q[29:15]});
				end
				default: op.vld = 1'b0;
			endcase
		end
	end

	spt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc_q  (acc_q)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (s_axis_tuser)
						ACT_ADD:  state_d = S_ADD;
						ACT_PICK: state_d = S_RD;
						ACT_DEL:  state_d = S_RD;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_ADD: state_d = S_DONE;
			S_RD:  state_d = (idx_q == cnt_q) ? S_DONE : S_CHK;
			S_CHK: begin
				if (act_q == ACT_PICK) begin
					state_d = S_MATH;
				end else begin
					state_d = key_match ? S_SH_RD : S_RD;
				end
			end
			S_MATH: begin
				if (step_q == STP_DXDX && !box_ok) begin
					state_d = S_RD;
				end else if (step_q == STP_LAST) begin
					state_d = hit ? S_DONE : S_RD;
				end
			end
			S_SH_RD: state_d = (idx_inc >= cnt_q) ? S_DONE : S_SH_WR;
			S_SH_WR: state_d = S_SH_RD;
			S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM controls.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_ADD: begin
				ram_we    = (cnt_q < MAX_CNT);
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = {ky2_q[CW-1:0], kx2_q[CW-1:0], ky1_q[CW-1:0], kx1_q[CW-1:0]};
			end
			S_SH_RD: ram_raddr = idx_inc[AW-1:0];
			S_SH_WR: ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	spt_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_SEGMENTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tol_q     <= TOL_RESET;
			cnt_q     <= '0;
			step_q    <= STP_DXDX;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (state_q == S_ADD && cnt_q < MAX_CNT) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == S_SH_RD && idx_inc >= cnt_q) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == S_MATH && state_d == S_MATH) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= STP_DXDX;
			end
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					act_q     <= s_axis_tuser;
					kx1_q     <= COORD_W'($signed(s_axis_tdata[0  +: CW]));
					ky1_q     <= COORD_W'($signed(s_axis_tdata[16 +: CW]));
					kx2_q     <= COORD_W'($signed(s_axis_tdata[32 +: CW]));
					ky2_q     <= COORD_W'($signed(s_axis_tdata[48 +: CW]));
					idx_q     <= '0;
					res_st_q  <= ST_NOMATCH;
					res_idx_q <= '0;
				end
			end
			S_ADD: begin
				if (cnt_q < MAX_CNT) begin
					res_st_q  <= ST_OK;
					res_idx_q <= cnt_q;
				end else begin
					res_st_q  <= ST_FULL;
				end
			end
			S_CHK: begin
				sx1_q <= rx1;
				sy1_q <= ry1;
				sx2_q <= rx2;
				sy2_q <= ry2;
				if (act_q != ACT_PICK) begin
					if (key_match) begin
						res_idx_q <= idx_q;
					end else begin
						idx_q <= idx_inc;
					end
				end
			end
			S_MATH: begin
				if (step_q == STP_DXY) begin
					len2_q <= acc_q[LEN_W-1:0];
				end
				if (step_q == STP_NUM) begin
					anum_q <= acc_abs[LEN_W-1:0];
				end
				if (step_q == STP_ALO) begin
					tol2_q <= acc_q[TOL2_W-1:0];
				end
				if (step_q == STP_DXDX && !box_ok) begin
					idx_q <= idx_inc;
				end else if (step_q == STP_LAST) begin
					if (hit) begin
						res_st_q  <= ST_OK;
						res_idx_q <= idx_q;
					end else begin
						idx_q <= idx_inc;
					end
				end
			end
			S_SH_RD: begin
				if (idx_inc >= cnt_q) begin
					res_st_q <= ST_OK;
				end
			end
			S_SH_WR: idx_q <= idx_inc;
			S_DONE: begin
				if (out_free) begin
					m_status_q <= res_st_q;
					m_index_q  <= 8'(res_idx_q);
				end
			end
			default: ;
		endcase
	end

	// The table never holds more than its capacity.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= MAX_CNT)
		else $error("segment count above capacity");

	// The count moves by at most one per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
		((cnt_q == $past(cnt_q) + 1'b1) || (cnt_q + 1'b1 == $past(cnt_q))))
		else $error("segment count jumped");

	// A failed request always reports index zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 8'd0))
		else $error("nonzero index on failed request");

	// The RAM is written only while adding or closing a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_ADD || state_q == S_SH_WR))
		else $error("unexpected table write");
endmodule

/* sim/segment_pick_table_test.sv */
`timescale 1ns / 100ps

// Self-checking bench for the segment pick table. Commands are queued by the
// stimulus process below, handed to the block by a clocked driver that works in
// bursts, and the results are collected by a clocked monitor that stalls on a
// pattern of its own. Every accepted command runs through a local copy of the
// table at the moment of its transfer, so the expected result is always known
// before the block answers.
module segment_pick_table_test;
	import spt_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam longint CYCLE_LIMIT = 2_000_000;

	typedef struct {
		logic [1:0]         act;
		logic signed [15:0] fx;
		logic signed [15:0] fy;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
	} wall_cmd_t;

	typedef struct {
		logic [1:0] status;
		logic [7:0] index;
	} wall_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [TOL_W-1:0] cfg_data = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [63:0]      s_axis_tdata = '0;
	logic [1:0]       s_axis_tuser = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;
	logic [1:0]       m_axis_tuser;

	segment_pick_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Commands waiting for the driver, and results owed by the block.
	wall_cmd_t    cmd_backlog[$];
	wall_result_t owed_results[$];

	// Local copy of the wall table, updated at each accepted command transfer.
	logic signed [15:0] wall_x1[TABLE_DEPTH];
	logic signed [15:0] wall_y1[TABLE_DEPTH];
	logic signed [15:0] wall_x2[TABLE_DEPTH];
	logic signed [15:0] wall_y2[TABLE_DEPTH];
	int unsigned        wall_count = 0;
	logic [TOL_W-1:0]   pick_tol = TOL_RESET;

	// The stimulus side keeps its own list of walls so it can aim picks and
	// deletes at segments that are really stored.
	wall_cmd_t planned_walls[$];

	int  fail_count = 0;
	int  cmds_sent = 0;
	int  results_seen = 0;
	int  hits_seen = 0;
	int  full_seen = 0;
	longint cycle_count = 0;

	// Point test against one stored wall: grown bounding box first, then the
	// squared perpendicular distance compared without any division.
	function automatic bit wall_is_hit(int unsigned i, longint px, longint py, longint tol);
		longint x1, y1, x2, y2, lox, hix, loy, hiy, dx, dy, num;
		logic [127:0] num_sq, limit, tol_sq, len_sq;
		x1 = wall_x1[i];
		y1 = wall_y1[i];
		x2 = wall_x2[i];
		y2 = wall_y2[i];
		lox = (x1 < x2) ? x1 : x2;
		hix = (x1 < x2) ? x2 : x1;
		loy = (y1 < y2) ? y1 : y2;
		hiy = (y1 < y2) ? y2 : y1;
		if (px + tol < lox || px - tol > hix || py + tol < loy || py - tol > hiy)
			return 1'b0;
		dx = x2 - x1;
		dy = y2 - y1;
		// A wall that collapses to a point is a hit once the box test passes.
		if (dx * dx + dy * dy == 0)
			return 1'b1;
		num = dy * px - dx * py + x2 * y1 - y2 * x1;
		if (num < 0)
			num = -num;
		num_sq = 128'(num);
		num_sq = num_sq * num_sq;
		tol_sq = 128'(tol * tol);
		len_sq = 128'(dx * dx + dy * dy);
		limit = tol_sq * len_sq;
		return num_sq <= limit;
	endfunction

	// Applies one command to the local table and returns the answer it owes.
	function automatic wall_result_t apply_wall_cmd(wall_cmd_t c);
		wall_result_t r;
		r.status = ST_NOMATCH;
		r.index = '0;
		case (c.act)
			ACT_ADD: begin
				if (wall_count < TABLE_DEPTH) begin
					wall_x1[wall_count] = c.fx;
					wall_y1[wall_count] = c.fy;
					wall_x2[wall_count] = c.sx;
					wall_y2[wall_count] = c.sy;
					r.status = ST_OK;
					r.index = 8'(wall_count);
					wall_count++;
				end else begin
					r.status = ST_FULL;
				end
			end
			ACT_PICK: begin
				for (int unsigned i = 0; i < wall_count; i++) begin
					if (wall_is_hit(i, c.fx, c.fy, pick_tol)) begin
						r.status = ST_OK;
						r.index = 8'(i);
						break;
					end
				end
			end
			ACT_DEL: begin
				for (int unsigned i = 0; i < wall_count; i++) begin
					if (wall_x1[i] == c.fx && wall_y1[i] == c.fy &&
					    wall_x2[i] == c.sx && wall_y2[i] == c.sy) begin
						// Close the gap so the remaining walls keep their order.
						for (int unsigned j = i; j + 1 < wall_count; j++) begin
							wall_x1[j] = wall_x1[j+1];
							wall_y1[j] = wall_y1[j+1];
							wall_x2[j] = wall_x2[j+1];
							wall_y2[j] = wall_y2[j+1];
						end
						wall_count--;
						r.status = ST_OK;
						r.index = 8'(i);
						break;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Driver: hands out queued commands in bursts of random length, with random
	// gaps between bursts. The command is only replaced after a transfer.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			wall_cmd_t c;
			if (s_axis_tvalid && s_axis_tready) begin
				c.act = s_axis_tuser;
				c.fx = s_axis_tdata[15:0];
				c.fy = s_axis_tdata[31:16];
				c.sx = s_axis_tdata[47:32];
				c.sy = s_axis_tdata[63:48];
				owed_results.insert(owed_results.size(), apply_wall_cmd(c));
				cmds_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					c = cmd_backlog.pop_front();
					s_axis_tuser <= c.act;
					s_axis_tdata <= {c.sy, c.sx, c.fy, c.fx};
					s_axis_tvalid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest owed result. The
	// ready pattern switches between free flow, random stalls and heavy stalls,
	// and once the run holds ready low for a long stretch so the output register
	// fills and the block stops taking commands.
	int  ready_mode = 0;
	int  mode_left = 0;
	int  long_hold = 0;
	bit  long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			wall_result_t want;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					$error("result transfer with nothing owed: status %0d index %0d",
					       m_axis_tuser, m_axis_tdata);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata !== want.index) begin
						$error("entry_index: expected %0d, got %0d", want.index, m_axis_tdata);
						fail_count++;
					end
					if (want.status == ST_OK)
						hits_seen++;
					if (want.status == ST_FULL)
						full_seen++;
				end
			end
			if (!long_hold_done && results_seen >= 60) begin
				long_hold_done = 1'b1;
				long_hold = 400;
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			if (long_hold > 0) begin
				long_hold--;
				m_axis_tready <= 1'b0;
			end else if (ready_mode == 0) begin
				m_axis_tready <= 1'b1;
			end else if (ready_mode == 1) begin
				m_axis_tready <= ($urandom_range(0, 1) == 1);
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("segment_pick_table regression: fail");
			$finish;
		end
	end

	// Queues a command and keeps the stimulus-side wall list in step with it.
	task automatic queue_cmd(logic [1:0] act, int fx, int fy, int sx, int sy);
		wall_cmd_t c;
		c.act = act;
		c.fx = 16'(fx);
		c.fy = 16'(fy);
		c.sx = 16'(sx);
		c.sy = 16'(sy);
		if (act == ACT_ADD && planned_walls.size() < TABLE_DEPTH)
			planned_walls.insert(planned_walls.size(), c);
		if (act == ACT_DEL) begin
			foreach (planned_walls[i]) begin
				if (planned_walls[i].fx == c.fx && planned_walls[i].fy == c.fy &&
				    planned_walls[i].sx == c.sx && planned_walls[i].sy == c.sy) begin
					planned_walls.delete(i);
					break;
				end
			end
		end
		cmd_backlog.insert(cmd_backlog.size(), c);
	endtask

	// Waits until every command has been answered and the block is idle.
	task automatic wait_quiet();
		while (cmd_backlog.size() > 0 || owed_results.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// Tolerance writes happen only while the block is idle.
	task automatic write_tolerance(logic [TOL_W-1:0] value);
		@(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		pick_tol = value;
	endtask

	function automatic int near_coord();
		return $urandom_range(0, 4000) - 2000;
	endfunction

	function automatic int any_coord();
		return $signed(16'($urandom()));
	endfunction

	// One random command; most picks and deletes aim at stored walls, and adds
	// stop once the planned list holds table_cap walls, to keep the scans short.
	task automatic queue_random_cmd(int table_cap);
		int roll, k, fx, fy, sx, sy;
		wall_cmd_t w;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			queue_cmd(ACT_NONE, any_coord(), any_coord(), any_coord(), any_coord());
		end else if (roll < 40 && planned_walls.size() < table_cap) begin
			if ($urandom_range(0, 4) == 0)
				queue_cmd(ACT_ADD, any_coord(), any_coord(), any_coord(), any_coord());
			else if ($urandom_range(0, 5) == 0) begin
				fx = near_coord();
				fy = near_coord();
				queue_cmd(ACT_ADD, fx, fy, fx, fy);
			end else
				queue_cmd(ACT_ADD, near_coord(), near_coord(), near_coord(), near_coord());
		end else if (roll < 75 || planned_walls.size() == 0) begin
			if (planned_walls.size() > 0 && $urandom_range(0, 3) != 0) begin
				w = planned_walls[$urandom_range(0, planned_walls.size() - 1)];
				fx = (int'(w.fx) + int'(w.sx)) / 2 + $urandom_range(0, 64) - 32;
				fy = (int'(w.fy) + int'(w.sy)) / 2 + $urandom_range(0, 64) - 32;
				queue_cmd(ACT_PICK, fx, fy, any_coord(), any_coord());
			end else
				queue_cmd(ACT_PICK, any_coord(), any_coord(), any_coord(), any_coord());
		end else begin
			if (planned_walls.size() > 0 && $urandom_range(0, 4) != 0) begin
				k = $urandom_range(0, planned_walls.size() - 1);
				w = planned_walls[k];
				queue_cmd(ACT_DEL, w.fx, w.fy, w.sx, w.sy);
			end else begin
				sx = near_coord();
				sy = near_coord();
				queue_cmd(ACT_DEL, near_coord(), near_coord(), sx, sy);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extreme coordinates, a collapsed wall, every action
		// including the unused one, misses, deletes that find nothing, and a
		// delete in the middle of the table.
		write_tolerance(TOL_RESET);
		queue_cmd(ACT_ADD, -32768, -32768, 32767, 32767);
		queue_cmd(ACT_ADD, 32767, -32768, -32768, 32767);
		queue_cmd(ACT_ADD, 100, 100, 100, 100);
		queue_cmd(ACT_ADD, 0, 0, 160, 0);
		queue_cmd(ACT_PICK, 100, 100, 0, 0);
		queue_cmd(ACT_PICK, -32768, -32768, -1, -1);
		queue_cmd(ACT_PICK, 32767, 32767, 0, 0);
		queue_cmd(ACT_PICK, 32767, -32768, 0, 0);
		queue_cmd(ACT_PICK, 2000, -30000, 0, 0);
		queue_cmd(ACT_NONE, -1, -1, -1, -1);
		queue_cmd(ACT_DEL, 1, 2, 3, 4);
		queue_cmd(ACT_DEL, -32768, -32768, 32767, 32767);
		queue_cmd(ACT_PICK, 116, 100, 0, 0);
		queue_cmd(ACT_PICK, 117, 100, 0, 0);
		queue_cmd(ACT_PICK, 80, 16, 0, 0);
		queue_cmd(ACT_PICK, 80, 17, 0, 0);
		queue_cmd(ACT_DEL, 100, 100, 100, 100);
		queue_cmd(ACT_PICK, 100, 100, 0, 0);
		queue_cmd(ACT_DEL, 32767, -32768, -32768, 32767);
		queue_cmd(ACT_DEL, 0, 0, 160, 0);
		queue_cmd(ACT_PICK, 0, 0, 0, 0);
		wait_quiet();

		// Random phases over a small table, at both ends of the tolerance range.
		write_tolerance('0);
		repeat (150) queue_random_cmd(24);
		wait_quiet();
		write_tolerance({TOL_W{1'b1}});
		repeat (100) queue_random_cmd(24);
		wait_quiet();

		// Fill the table to the top, push past it, then pick and delete on a
		// full table.
		write_tolerance(TOL_W'($urandom_range(1, 200)));
		while (planned_walls.size() < TABLE_DEPTH)
			queue_cmd(ACT_ADD, near_coord(), near_coord(), near_coord(), near_coord());
		repeat (3) queue_cmd(ACT_ADD, any_coord(), any_coord(), any_coord(), any_coord());
		repeat (12) queue_random_cmd(TABLE_DEPTH);
		wait_quiet();

		repeat (20) @(posedge clk);
		if (owed_results.size() != 0) begin
			$error("%0d results never arrived", owed_results.size());
			fail_count++;
		end
		$display("Covered %0d commands and %0d results: %0d ok, %0d table-full answers.",
		         cmds_sent, results_seen, hits_seen, full_seen);
		$display("Tolerance ran at zero, the maximum and a random middle value.");
		if (fail_count == 0) begin
			$display("segment_pick_table regression: pass");
		end else begin
			$display("segment_pick_table regression: fail");
		end
		$finish;
	end

endmodule
